// ===== sv/msd_pkg.sv =====
package msd_pkg;

   localparam logic [7:0] SX_START   = 8'hF0;
   localparam logic [7:0] SX_END     = 8'hF7;
   localparam logic [7:0] RT_FIRST   = 8'hF8;
   localparam int         BYTE_W     = 8;
   localparam int         WORD_W     = 32;
   localparam int         LEN_W      = 7;
   localparam logic [1:0] LAST_SLOT  = 2'd3;

   typedef enum logic [1:0] {
      SC_IDLE = 2'b01,
      SC_BUSY = 2'b10
   } scan_state_type;

   typedef enum logic [2:0] {
      EM_IDLE = 3'b001,
      EM_READ = 3'b010,
      EM_SHOW = 3'b100
   } emit_state_type;

endpackage

// ===== sv/msd_scan.sv =====
module msd_scan
   import msd_pkg::*;
#(
   parameter int MaxLen = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [WORD_W-1:0]              req_event_word,
   input  logic                           emit_busy,
   output logic                           wr_en,
   output logic [$clog2(MaxLen)-1:0]      wr_addr,
   output logic [BYTE_W-1:0]              wr_data,
   output logic                           start_valid,
   output logic [$clog2(MaxLen+1)-1:0]    start_len
);

   localparam int AW = $clog2(MaxLen);
   localparam int LW = $clog2(MaxLen + 1);

   scan_state_type    state_ff, state_in;
   logic [WORD_W-1:0] shift_ff, shift_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [LW-1:0]     fill_ff, fill_in;
   logic [BYTE_W-1:0] cur;
   logic              accept;
   logic              stop;

   assign req_stall = (state_ff != SC_IDLE) | emit_busy;
   assign accept    = req_valid & ~req_stall;
   assign cur       = shift_ff[BYTE_W-1:0];

   always_comb begin
      state_in    = state_ff;
      shift_in    = shift_ff;
      cnt_in      = cnt_ff;
      fill_in     = fill_ff;
      wr_en       = 1'b0;
      wr_addr     = fill_ff[AW-1:0];
      wr_data     = cur;
      start_valid = 1'b0;
      start_len   = fill_ff + LW'(1);
      stop        = 1'b0;
      case (state_ff)
         SC_IDLE: begin
            if (accept && (req_event_word[BYTE_W-1:0] < RT_FIRST)) begin
               shift_in = req_event_word;
               cnt_in   = 2'd0;
               state_in = SC_BUSY;
            end
         end
         SC_BUSY: begin
            if (cur == SX_START) begin
               wr_en   = 1'b1;
               wr_addr = '0;
               fill_in = LW'(1);
            end else if (fill_ff == '0) begin
               stop = 1'b0;
            end else if (cur[BYTE_W-1] && (cur != SX_END)) begin
               fill_in = '0;
               stop    = 1'b1;
            end else if (fill_ff >= LW'(MaxLen)) begin
               fill_in = '0;
               stop    = (cur == SX_END);
            end else begin
               wr_en   = 1'b1;
               fill_in = fill_ff + LW'(1);
               if (cur == SX_END) begin
                  start_valid = 1'b1;
                  fill_in     = '0;
                  stop        = 1'b1;
               end
            end
            if (stop || (cnt_ff == LAST_SLOT)) begin
               state_in = SC_IDLE;
            end else begin
               cnt_in   = cnt_ff + 2'd1;
               shift_in = shift_ff >> BYTE_W;
            end
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         fill_ff  <= '0;
         cnt_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         cnt_ff   <= cnt_in;
      end
      shift_ff <= shift_in;
   end

endmodule

// ===== sv/msd_emit.sv =====
module msd_emit
   import msd_pkg::*;
#(
   parameter int MaxLen = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [$clog2(MaxLen)-1:0]      wr_addr,
   input  logic [BYTE_W-1:0]              wr_data,
   input  logic                           start_valid,
   input  logic [$clog2(MaxLen+1)-1:0]    start_len,
   output logic                           emit_busy,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [BYTE_W-1:0]              rsp_msg_byte,
   output logic                           rsp_is_last,
   output logic [LEN_W-1:0]               rsp_msg_length
);

   localparam int AW = $clog2(MaxLen);
   localparam int LW = $clog2(MaxLen + 1);

   logic [BYTE_W-1:0] mem [MaxLen];

   emit_state_type    state_ff, state_in;
   logic [AW-1:0]     k_ff, k_in;
   logic [LW-1:0]     n_ff, n_in;
   logic              last_ff, last_in;
   logic [BYTE_W-1:0] rd_data_ff;
   logic              rd_en;

   assign emit_busy      = (state_ff != EM_IDLE);
   assign rsp_valid      = (state_ff == EM_SHOW);
   assign rsp_msg_byte   = rd_data_ff;
   assign rsp_is_last    = last_ff;
   assign rsp_msg_length = LEN_W'(n_ff);
   assign rd_en          = (state_ff == EM_READ);

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      n_in     = n_ff;
      last_in  = last_ff;
      case (state_ff)
         EM_IDLE: begin
            if (start_valid) begin
               n_in     = start_len;
               k_in     = '0;
               state_in = EM_READ;
            end
         end
         EM_READ: begin
            last_in  = ((LW'(k_ff) + LW'(1)) == n_ff);
            state_in = EM_SHOW;
         end
         EM_SHOW: begin
            if (!rsp_stall) begin
               if (last_ff) begin
                  state_in = EM_IDLE;
               end else begin
                  k_in     = k_ff + AW'(1);
                  state_in = EM_READ;
               end
            end
         end
         default: begin
            state_in = EM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[k_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EM_IDLE;
      end else begin
         state_ff <= state_in;
      end
      k_ff    <= k_in;
      n_ff    <= n_in;
      last_ff <= last_in;
   end

endmodule

// ===== sv/midi_sysex_deframer.sv =====
// Deframer for SysEx messages carried in 32-bit MIDI event words.
// Input channel (req_): one event word per transfer, first byte in bits 7..0.
// A word whose first byte is a real-time status is taken and dropped whole.
// Otherwise the scanner walks up to four bytes, one per cycle, and holds
// the input stalled until it is done with the word.
// Result channel (rsp_): when an F7 byte closes a message, every byte from
// F0 through F7 is sent as its own transfer, with rsp_is_last on the F7 and
// rsp_msg_length giving the byte count on every one of them. Each byte goes
// through a store read state and then a show state, which presents the
// byte from the read register; the first one follows the cycle that scanned
// the F7. The input stays stalled until the last byte of a message has
// been taken. While the receiver stalls, the current byte is held and
// nothing advances.
// Messages longer than MAX_LEN bytes are dropped without any output.
// Reset clears the open message and both sequencers; the message store
// needs no clearing, since only bytes of the current message are read.
module midi_sysex_deframer
   import msd_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [WORD_W-1:0] req_event_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_msg_byte,
   output logic              rsp_is_last,
   output logic [LEN_W-1:0]  rsp_msg_length
);

   localparam int AW = $clog2(MAX_LEN);
   localparam int LW = $clog2(MAX_LEN + 1);

   logic              emit_busy;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              start_valid;
   logic [LW-1:0]     start_len;

   msd_scan #(.MaxLen(MAX_LEN)) u_scan (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_event_word (req_event_word),
      .emit_busy      (emit_busy),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .start_valid    (start_valid),
      .start_len      (start_len)
   );

   msd_emit #(.MaxLen(MAX_LEN)) u_emit (
      .clock          (clock),
      .reset          (reset),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .start_valid    (start_valid),
      .start_len      (start_len),
      .emit_busy      (emit_busy),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_msg_byte   (rsp_msg_byte),
      .rsp_is_last    (rsp_is_last),
      .rsp_msg_length (rsp_msg_length)
   );

endmodule

// ===== sv/msd_checker.sv =====
module msd_checker
   import msd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [BYTE_W-1:0] rsp_msg_byte,
   input logic              rsp_is_last,
   input logic [LEN_W-1:0]  rsp_msg_length
);

   logic rsp_xfer;
   assign rsp_xfer = rsp_valid & ~rsp_stall;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_last_is_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_last) |-> (rsp_msg_byte == SX_END))
      else $error("final byte of a message is not F7");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a message is sent");

   a_length_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && !rsp_is_last) |=> ##1
         (rsp_valid && (rsp_msg_length == $past(rsp_msg_length, 2))))
      else $error("message length changed within a message");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_msg_byte) && $stable(rsp_is_last)))
      else $error("stalled result changed");

endmodule

bind midi_sysex_deframer msd_checker u_msd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_msg_byte   (rsp_msg_byte),
   .rsp_is_last    (rsp_is_last),
   .rsp_msg_length (rsp_msg_length)
);
